/* src/sarg_pkg.sv */
package sarg_pkg;

   // Longest check block in samples
   localparam int MAX_BLOCK_LEN = 4096;

   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 16;
   localparam int COUNT_W     = 16;
   localparam int BLOCK_LEN_W = 13;
   localparam int POS_W       = $clog2(MAX_BLOCK_LEN);
   localparam int LEN_W       = $clog2(MAX_BLOCK_LEN + 1);
   localparam int SUM_W       = POS_W + SAMPLE_W;
   localparam int THR_W       = LEVEL_W + LEN_W;
   localparam int CMP_W       = (LEN_W > BLOCK_LEN_W) ? LEN_W : BLOCK_LEN_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_LEVEL      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_BLOCKS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BLOCKS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_KEEP_BLOCKS = 3'd5;

   localparam int BLOCK_LEN_RST       = 64;
   localparam int TRIGGER_LEVEL_RST   = 2000;
   localparam int KEEP_LEVEL_RST      = 1800;
   localparam int HOLD_BLOCKS_RST     = 625;
   localparam int MAX_BLOCKS_RST      = 2500;
   localparam int MIN_KEEP_BLOCKS_RST = 1250;

   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   typedef enum logic {
      MODE_LISTEN,
      MODE_RECORD
   } mode_type;

   // Working configuration as seen by the gate
   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [THR_W-1:0]   trigger_thr;
      logic [THR_W-1:0]   keep_thr;
      logic [COUNT_W-1:0] hold_blocks;
      logic [COUNT_W-1:0] max_blocks;
      logic [COUNT_W-1:0] min_keep_blocks;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] recorded_sample;
      logic                       recording;
      logic                       block_end;
      logic                       loud;
      logic                       take_start;
      logic                       take_end;
      logic                       take_kept;
   } result_type;

endpackage

/* src/sarg_if.sv */
interface sarg_req_if import sarg_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface sarg_rsp_if import sarg_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] recorded_sample;
   logic                       recording;
   logic                       block_end;
   logic                       loud;
   logic                       take_start;
   logic                       take_end;
   logic                       take_kept;

   modport source (output valid, output recorded_sample, output recording, output block_end,
                   output loud, output take_start, output take_end, output take_kept,
                   input ready);
   modport sink   (input valid, input recorded_sample, input recording, input block_end,
                   input loud, input take_start, input take_end, input take_kept,
                   output ready);
endinterface

/* src/sarg_csr.sv */
module sarg_csr import sarg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [BLOCK_LEN_W-1:0] block_len_ff;
   logic [LEVEL_W-1:0]     trigger_level_ff;
   logic [LEVEL_W-1:0]     keep_level_ff;
   logic [COUNT_W-1:0]     hold_blocks_ff;
   logic [COUNT_W-1:0]     max_blocks_ff;
   logic [COUNT_W-1:0]     min_keep_blocks_ff;

   logic [LEN_W-1:0] len_in, len_ff;
   logic [THR_W-1:0] trigger_thr_in, trigger_thr_ff;
   logic [THR_W-1:0] keep_thr_in, keep_thr_ff;
   logic [CMP_W-1:0] raw_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff       <= BLOCK_LEN_W'(BLOCK_LEN_RST);
         trigger_level_ff   <= LEVEL_W'(TRIGGER_LEVEL_RST);
         keep_level_ff      <= LEVEL_W'(KEEP_LEVEL_RST);
         hold_blocks_ff     <= COUNT_W'(HOLD_BLOCKS_RST);
         max_blocks_ff      <= COUNT_W'(MAX_BLOCKS_RST);
         min_keep_blocks_ff <= COUNT_W'(MIN_KEEP_BLOCKS_RST);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_LEN:       block_len_ff       <= csr_wdata[BLOCK_LEN_W-1:0];
            CSR_TRIGGER_LEVEL:   trigger_level_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_KEEP_LEVEL:      keep_level_ff      <= csr_wdata[LEVEL_W-1:0];
            CSR_HOLD_BLOCKS:     hold_blocks_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_MAX_BLOCKS:      max_blocks_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_MIN_KEEP_BLOCKS: min_keep_blocks_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the block length to 1 .. MAX_BLOCK_LEN
   always_comb begin
      raw_len = CMP_W'(block_len_ff);
      if (raw_len == '0)
         len_in = LEN_W'(1);
      else if (raw_len > CMP_W'(MAX_BLOCK_LEN))
         len_in = LEN_W'(MAX_BLOCK_LEN);
      else
         len_in = LEN_W'(raw_len);
   end

   // Level times length, so the block mean never needs a divide
   assign trigger_thr_in = THR_W'(trigger_level_ff) * THR_W'(len_in);
   assign keep_thr_in    = THR_W'(keep_level_ff) * THR_W'(len_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= LEN_W'(BLOCK_LEN_RST);
         trigger_thr_ff <= THR_W'(TRIGGER_LEVEL_RST * BLOCK_LEN_RST);
         keep_thr_ff    <= THR_W'(KEEP_LEVEL_RST * BLOCK_LEN_RST);
      end else begin
         len_ff         <= len_in;
         trigger_thr_ff <= trigger_thr_in;
         keep_thr_ff    <= keep_thr_in;
      end
   end

   assign cfg.len             = len_ff;
   assign cfg.trigger_thr     = trigger_thr_ff;
   assign cfg.keep_thr        = keep_thr_ff;
   assign cfg.hold_blocks     = hold_blocks_ff;
   assign cfg.max_blocks      = max_blocks_ff;
   assign cfg.min_keep_blocks = min_keep_blocks_ff;

endmodule

/* src/sarg_gate.sv */
module sarg_gate import sarg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  cfg_type                    cfg,
   output result_type                 result
);

   mode_type           mode_ff, mode_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] quiet_ff, quiet_in;
   logic [COUNT_W-1:0] take_ff, take_in;

   logic [SAMPLE_W-1:0] mag;
   logic [SUM_W-1:0]    sum_new;
   logic [THR_W-1:0]    thr;
   logic [COUNT_W-1:0]  quiet_inc;
   logic [COUNT_W-1:0]  take_inc;
   logic                rec;
   logic                bend;
   logic                loud;
   logic                stop;

   // Full-scale negative comes out as 32768, which still fits unsigned
   assign mag       = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
   assign sum_new   = sum_ff + SUM_W'(mag);
   assign rec       = (mode_ff == MODE_RECORD);
   assign bend      = (LEN_W'(pos_ff) + LEN_W'(1)) >= cfg.len;
   assign thr       = rec ? cfg.keep_thr : cfg.trigger_thr;
   assign loud      = bend && (THR_W'(sum_new) >= thr);
   assign quiet_inc = quiet_ff + COUNT_W'(quiet_ff != COUNT_SAT);
   assign take_inc  = take_ff + COUNT_W'(take_ff != COUNT_SAT);
   assign stop      = rec && bend &&
                      ((quiet_inc >= cfg.hold_blocks) || (take_inc >= cfg.max_blocks));

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_LISTEN: if (loud) mode_in = MODE_RECORD;
         MODE_RECORD: if (stop) mode_in = MODE_LISTEN;
         default:     mode_in = MODE_LISTEN;
      endcase
   end

   // Block position, sum, take counters and the result beat
   always_comb begin
      pos_in   = bend ? '0 : pos_ff + POS_W'(1);
      sum_in   = bend ? '0 : sum_new;
      quiet_in = quiet_ff;
      take_in  = take_ff;
      if (bend) begin
         if (!rec) begin
            if (loud) begin
               quiet_in = '0;
               take_in  = '0;
            end
         end else if (stop) begin
            quiet_in = '0;
            take_in  = '0;
         end else begin
            take_in  = take_inc;
            quiet_in = loud ? '0 : quiet_inc;
         end
      end

      result.recorded_sample = rec ? sample : '0;
      result.recording       = rec;
      result.block_end       = bend;
      result.loud            = loud;
      result.take_start      = !rec && loud;
      result.take_end        = stop;
      result.take_kept       = stop && (take_inc >= cfg.min_keep_blocks);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_LISTEN;
         pos_ff   <= '0;
         sum_ff   <= '0;
         quiet_ff <= '0;
         take_ff  <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         quiet_ff <= quiet_in;
         take_ff  <= take_in;
      end
   end

endmodule

/* src/sound_activated_record_gate.sv */
// Channel | Dir | Beat
// req     | in  | sample (signed 16)
// rsp     | out | recorded_sample, recording, block_end, loud, take_start, take_end, take_kept
// csr     | in  | csr_we, csr_index, csr_wdata (write only)
//
// One rsp beat per req beat; a new req beat is taken every cycle while rsp is not stalled.
// A beat passes through the input register, then the gate logic into the result register.
// The block mean test uses level*length products registered from the config registers a csr write updates.
// Synchronous reset restores the registers and returns the gate to listening.
// A stalled rsp holds its beat; req keeps flowing until the input register is also full.
module sound_activated_record_gate import sarg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sarg_req_if.sink              req,
   sarg_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type result_ff;

   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       out_valid_ff;
   logic                       out_free;
   logic                       advance;
   logic                       req_take;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !reset && (!in_valid_ff || advance);
   assign req_take  = req.valid && req.ready;

   sarg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sarg_gate u_gate (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_sample_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take)
            in_valid_ff <= 1'b1;
         else if (advance)
            in_valid_ff <= 1'b0;
         if (advance)
            out_valid_ff <= 1'b1;
         else if (rsp.ready)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_sample_ff <= req.sample;
      if (advance)
         result_ff <= result;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.recorded_sample = result_ff.recorded_sample;
   assign rsp.recording       = result_ff.recording;
   assign rsp.block_end       = result_ff.block_end;
   assign rsp.loud            = result_ff.loud;
   assign rsp.take_start      = result_ff.take_start;
   assign rsp.take_end        = result_ff.take_end;
   assign rsp.take_kept       = result_ff.take_kept;

   // A take ends only on a recorded sample
   a_end_recorded: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.take_end |-> rsp.recording)
      else $error("take_end outside a take");

   // A trigger block is never part of the take
   a_start_listening: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.take_start |-> !rsp.recording && rsp.block_end)
      else $error("take_start while recording");

   // A held input beat is not lost while the result side stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_sample_ff))
      else $error("input beat dropped under stall");

   // Every advance leaves a result beat waiting
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result beat lost");

endmodule

/* dv/tb_sound_activated_record_gate.sv */
`timescale 1ns / 1ps

module tb_sound_activated_record_gate;
   import sarg_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int IDLE_PCT    = 12;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sarg_req_if req ();
   sarg_rsp_if rsp ();

   sound_activated_record_gate u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the configuration registers
   int unsigned cfg_block_len   = BLOCK_LEN_RST;
   int unsigned cfg_trigger     = TRIGGER_LEVEL_RST;
   int unsigned cfg_keep        = KEEP_LEVEL_RST;
   int unsigned cfg_hold        = HOLD_BLOCKS_RST;
   int unsigned cfg_max         = MAX_BLOCKS_RST;
   int unsigned cfg_min_keep    = MIN_KEEP_BLOCKS_RST;

   // Predicted gate state
   mode_type        gate_mode   = MODE_LISTEN;
   int unsigned     gate_pos    = 0;
   longint unsigned gate_sum    = 0;
   int unsigned     gate_quiet  = 0;
   int unsigned     gate_take   = 0;

   result_type pending_beats[$];
   bit         idle_en;
   int         err_count;
   int         cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("sound_activated_record_gate verification failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp.ready <= !(idle_en && ($urandom_range(99) < IDLE_PCT));

   function automatic result_type predict_gate_beat(input logic [SAMPLE_W-1:0] raw);
      result_type      r;
      int unsigned     mag;
      int unsigned     len;
      longint unsigned level;
      logic            rec;
      mag = raw[SAMPLE_W-1] ? (32'd65536 - raw) : raw;
      len = cfg_block_len;
      if (len == 0) len = 1;
      if (len > MAX_BLOCK_LEN) len = MAX_BLOCK_LEN;
      rec = (gate_mode == MODE_RECORD);
      r = '0;
      gate_sum += mag;
      if (gate_pos + 1 >= len) begin
         level = rec ? cfg_keep : cfg_trigger;
         r.block_end = 1'b1;
         r.loud = (gate_sum >= level * len);
         gate_pos = 0;
         gate_sum = 0;
         if (!rec) begin
            if (r.loud) begin
               r.take_start = 1'b1;
               gate_mode = MODE_RECORD;
               gate_quiet = 0;
               gate_take = 0;
            end
         end else begin
            if (gate_take < 32'hFFFF) gate_take++;
            if (gate_quiet < 32'hFFFF) gate_quiet++;
            // stop rule wins over the loud rule
            if (gate_quiet >= cfg_hold || gate_take >= cfg_max) begin
               r.take_end = 1'b1;
               r.take_kept = (gate_take >= cfg_min_keep);
               gate_mode = MODE_LISTEN;
               gate_quiet = 0;
               gate_take = 0;
            end else if (r.loud) begin
               gate_quiet = 0;
            end
         end
      end else begin
         gate_pos = (gate_pos + 1) & 32'hFFFF;
      end
      r.recording = rec;
      r.recorded_sample = rec ? raw : '0;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         err_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_beat
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_beats.size() == 0) begin
            err_count++;
            $display("%0t: beat with no prediction pending, expected none, actual %0h",
                     $time, rsp.recorded_sample);
         end else begin
            want = pending_beats.pop_front();
            check_field("recorded_sample", want.recorded_sample, rsp.recorded_sample);
            check_field("recording", want.recording, rsp.recording);
            check_field("block_end", want.block_end, rsp.block_end);
            check_field("loud", want.loud, rsp.loud);
            check_field("take_start", want.take_start, rsp.take_start);
            check_field("take_end", want.take_end, rsp.take_end);
            check_field("take_kept", want.take_kept, rsp.take_kept);
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while (idle_en && ($urandom_range(99) < IDLE_PCT)) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.sample <= s;
      do @(posedge clock); while (!req.ready);
      pending_beats.push_back(predict_gate_beat(s));
   endtask

   // Drop valid and hold until every predicted beat has come back
   task automatic drain_gate();
      req.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_BLOCK_LEN:       cfg_block_len = val & 16'h1FFF;
         CSR_TRIGGER_LEVEL:   cfg_trigger = val;
         CSR_KEEP_LEVEL:      cfg_keep = val;
         CSR_HOLD_BLOCKS:     cfg_hold = val;
         CSR_MAX_BLOCKS:      cfg_max = val;
         CSR_MIN_KEEP_BLOCKS: cfg_min_keep = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [15:0] bl, input logic [15:0] trig,
                               input logic [15:0] keep, input logic [15:0] hold,
                               input logic [15:0] maxb, input logic [15:0] mink);
      write_csr(CSR_BLOCK_LEN, bl);
      write_csr(CSR_TRIGGER_LEVEL, trig);
      write_csr(CSR_KEEP_LEVEL, keep);
      write_csr(CSR_HOLD_BLOCKS, hold);
      write_csr(CSR_MAX_BLOCKS, maxb);
      write_csr(CSR_MIN_KEEP_BLOCKS, mink);
      csr_we <= 1'b0;
      // let the level*length products settle
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] shaped_sample(input int lo, input int hi);
      int mag;
      if (lo < 0) lo = 0;
      if (lo > 32768) lo = 32768;
      if (hi > 32768) hi = 32768;
      if (hi < lo) hi = lo;
      mag = $urandom_range(hi, lo);
      if (mag == 32768 || $urandom_range(1) == 1) return 16'(-mag);
      return 16'(mag);
   endfunction

   task automatic test_reset_defaults();
      for (int i = 0; i < 64; i++) send_sample(16'h8000);
      for (int i = 0; i < 4; i++) send_sample(16'($urandom));
      drain_gate();
   endtask

   task automatic test_extremes();
      logic [15:0] seq [10];
      seq = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
              16'h0001, 16'h8000, 16'h8000, 16'h8001, 16'h7FFF};
      // full-scale trigger: only minus full scale reaches it
      apply_config(16'd1, 16'd32768, 16'd0, 16'd2, 16'd3, 16'd2);
      foreach (seq[i]) send_sample(seq[i]);
      drain_gate();
   endtask

   task automatic test_stop_rules();
      // zero hold and maximum end the take at its first block end
      apply_config(16'd1, 16'd0, 16'd32768, 16'd0, 16'd0, 16'd0);
      send_sample(16'h0000);
      send_sample(16'h0005);
      send_sample(16'h0003);
      drain_gate();
      // stop on quiet blocks, not kept
      apply_config(16'd1, 16'd0, 16'd32768, 16'd1, 16'd100, 16'd2);
      send_sample(16'h0000);
      send_sample(16'h0007);
      drain_gate();
      // stop on maximum length, kept
      apply_config(16'd1, 16'd0, 16'd0, 16'd3, 16'd2, 16'd2);
      send_sample(16'h1234);
      send_sample(16'hEDCB);
      send_sample(16'h4000);
      drain_gate();
   endtask

   task automatic test_len_change();
      apply_config(16'd5, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 3; i++) send_sample(16'($urandom));
      drain_gate();
      // shorter length mid-block: the next sample closes the block
      apply_config(16'd2, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'($urandom));
      send_sample(16'($urandom));
      drain_gate();
      // zero length behaves as one
      apply_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'($urandom));
      send_sample(16'($urandom));
      drain_gate();
   endtask

   task automatic test_oversized_len();
      // all ones masks to 8191 and clamps to the longest block; no block closes early
      apply_config(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
      for (int i = 0; i < 150; i++) send_sample(16'($urandom));
      drain_gate();
   endtask

   task automatic test_random_takes();
      int bl;
      int trig;
      int keep;
      int hold;
      int maxb;
      int mink;
      int bl_eff;
      int target;
      int count;
      int seg;
      int seg_len;
      int kind;
      int lvl;
      for (int phase = 0; phase < 12; phase++) begin
         bl = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         if ($urandom_range(15) == 0) bl = 0;
         case ($urandom_range(9))
            0:       trig = 0;
            1:       trig = 32768;
            2:       trig = $urandom_range(65535);
            default: trig = $urandom_range(20000, 500);
         endcase
         case ($urandom_range(9))
            0:       keep = 0;
            1:       keep = 32768;
            default: keep = $urandom_range(18000, 200);
         endcase
         hold = ($urandom_range(11) == 0) ? 0 : $urandom_range(6, 1);
         case ($urandom_range(11))
            0:       maxb = 0;
            1:       maxb = 65535;
            default: maxb = $urandom_range(24, 1);
         endcase
         mink = $urandom_range((maxb > 30) ? 30 : maxb + 2, 0);
         apply_config(16'(bl), 16'(trig), 16'(keep), 16'(hold), 16'(maxb), 16'(mink));
         bl_eff = (bl == 0) ? 1 : bl;
         // one long stretch with no idling on either side
         idle_en = (phase != 5);
         target = (phase == 5) ? 200 : 70;
         count = 0;
         seg = 0;
         while (count < target) begin
            kind = $urandom_range(9);
            seg_len = bl_eff * $urandom_range(4, 1);
            lvl = ($urandom_range(1) == 1) ? trig : keep;
            for (int k = 0; k < seg_len; k++) begin
               case (kind)
                  0, 1, 2, 3: send_sample(shaped_sample((trig > keep) ? trig : keep, 32768));
                  4, 5, 6:    send_sample(shaped_sample(0, ((trig < keep) ? trig : keep) / 2));
                  7, 8:       send_sample(shaped_sample(lvl - 300, lvl + 300));
                  default:    send_sample(16'($urandom));
               endcase
            end
            count += seg_len;
            seg++;
            if ((phase == 1 && seg == 2) || $urandom_range(29) == 0) drain_gate();
         end
         drain_gate();
      end
      idle_en = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BLOCK_LEN;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.sample = '0;
      rsp.ready = 1'b0;
      idle_en = 1'b1;
      err_count = 0;
      cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_extremes();
      test_stop_rules();
      test_len_change();
      test_oversized_len();
      test_random_takes();

      drain_gate();
      repeat (8) @(posedge clock);
      if (err_count == 0 && pending_beats.size() == 0) begin
         $display("sound_activated_record_gate verification clean");
      end else begin
         $display("sound_activated_record_gate verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/sarg_pkg.sv
src/sarg_if.sv
src/sarg_csr.sv
src/sarg_gate.sv
src/sound_activated_record_gate.sv
dv/tb_sound_activated_record_gate.sv
